### hw/rtl/vertical_counter_debounce_events_unit_macros.svh
// Assertion helpers shared by the debounce block.
`ifndef VERTICAL_COUNTER_DEBOUNCE_EVENTS_UNIT_MACROS_SVH
`define VERTICAL_COUNTER_DEBOUNCE_EVENTS_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VCDE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vcde assertion failed");

// Next-cycle implication, disabled during reset.
`define VCDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vcde assertion failed");

`endif

### hw/rtl/vcde_pkg.sv
package vcde_pkg;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_SCAN
  } state_t;

  // config register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_EVENT_HASH = 2'd0;
  localparam cfg_idx_t CFG_DEVICE_ID  = 2'd1;
  localparam cfg_idx_t CFG_BUS_GROUP  = 2'd2;

  localparam logic [31:0] FRAME_BASE  = 32'h0023_0300;
  localparam logic [15:0] HASH_MASK   = 16'hffff;
  localparam logic [15:0] GROUP_SCALE = 16'd256;

  // sequencer controls toward the datapath
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic calc;
    logic step;
    logic load_out;
  } ctrl_t;

endpackage

### hw/rtl/vcde_state_mem.sv
module vcde_state_mem #(
  parameter int WORDS = 4,
  parameter int DW    = 96,
  parameter int AW    = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0]    mem [WORDS];
  logic [WORDS-1:0] valid_r;
  logic [DW-1:0]    rd_data_r;
  logic             rd_hit_r;

  // entries never written read as all ones (reset value)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_hit_r <= 1'b0;
    end else if (rd_en) begin
      rd_hit_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_hit_r ? rd_data_r : '1;

endmodule

### hw/rtl/vcde_update.sv
module vcde_update #(
  parameter int WORD_BITS = 32
) (
  input  logic [WORD_BITS-1:0] sample,
  input  logic [WORD_BITS-1:0] cnt_low,
  input  logic [WORD_BITS-1:0] cnt_high,
  input  logic [WORD_BITS-1:0] stable_inv,
  output logic [WORD_BITS-1:0] cnt_low_nxt,
  output logic [WORD_BITS-1:0] cnt_high_nxt,
  output logic [WORD_BITS-1:0] stable_inv_nxt,
  output logic [WORD_BITS-1:0] fired
);

  logic [WORD_BITS-1:0] diff;

  // diff: sample disagrees with debounced level; counter counts down to 00
  always_comb begin
    diff           = stable_inv ^ ~sample;
    cnt_low_nxt    = ~(cnt_low & diff);
    cnt_high_nxt   = cnt_low_nxt ^ (cnt_high & diff);
    fired          = diff & cnt_low_nxt & cnt_high_nxt;
    stable_inv_nxt = stable_inv ^ fired;
  end

endmodule

### hw/rtl/vertical_counter_debounce_events_unit.sv
// Vertical-counter debouncer with per-contact change events. Each input
// transaction carries one raw sample word and its word index; every bit has a
// 2-bit vertical counter, and a level that differs from the debounced level
// for four samples in a row becomes the new debounced level. For every bit
// that changed, lowest bit first, one output transaction is sent with the
// frame id, device number, contact number (bus_group*256 + word*WORD_BITS +
// bit + 1, modulo 65536) and the old and new levels; the final one of a
// sample has out_last_event set. A sample whose word index is WORDS or more
// is accepted and dropped. Sequence: an accept step (state memory read), an
// update step (counter update and write-back), then a shift-scan over the
// changed-bit mask, one bit per cycle while a changed bit is not waiting for
// a free output register, up to and including the highest changed bit, and a
// closing scan step on the empty mask. A new sample is accepted only once the
// scan has ended. The scan shifter and the contact incrementer are shared by
// all bits of a sample. The state memory needs no clearing pass after reset:
// per-word valid bits make unwritten words read as all ones. Config writes are
// taken any cycle but must only be issued while the block is idle.
module vertical_counter_debounce_events_unit #(
  parameter int WORDS     = 4,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // config port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // sample transactions
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_sample_word,
  input  logic [1:0]  in_word_index,
  // event transactions
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_frame_id,
  output logic [15:0] out_device_number,
  output logic [15:0] out_contact,
  output logic        out_old_level,
  output logic        out_new_level,
  output logic        out_last_event
);

`include "vertical_counter_debounce_events_unit_macros.svh"

  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int DW = 3 * WORD_BITS;

  vcde_pkg::state_t state_r, state_nxt;
  vcde_pkg::ctrl_t  ctrl;

  // config registers
  logic [15:0] event_hash_r;
  logic [15:0] device_id_r;
  logic [7:0]  bus_group_r;

  // per-sample working registers
  logic [WORD_BITS-1:0] sample_r;
  logic [1:0]           widx_r;
  logic [WORD_BITS-1:0] fired_r;   // changed bits still to scan
  logic [WORD_BITS-1:0] level_r;   // sample bits, shifted along with fired_r
  logic [15:0]          contact_r;

  // output register
  logic        out_valid_r;
  logic [31:0] out_frame_id_r;
  logic [15:0] out_device_number_r;
  logic [15:0] out_contact_r;
  logic        out_old_level_r;
  logic        out_new_level_r;
  logic        out_last_event_r;

  logic                 in_acc;
  logic                 word_ok;
  logic                 out_free;
  logic                 last_nxt;
  logic [DW-1:0]        rd_data;
  logic [DW-1:0]        wr_data;
  logic [WORD_BITS-1:0] cl_nxt, ch_nxt, si_nxt, fired;
  logic [15:0]          contact_base;

  assign in_acc   = in_valid && in_ready;
  assign word_ok  = 32'(in_word_index) < 32'(WORDS);
  assign out_free = !out_valid_r || out_ready;
  assign last_nxt = (fired_r >> 1) == '0;

  // ---------------- config ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      event_hash_r <= '0;
      device_id_r  <= '0;
      bus_group_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vcde_pkg::CFG_EVENT_HASH: event_hash_r <= cfg_wdata;
        vcde_pkg::CFG_DEVICE_ID:  device_id_r  <= cfg_wdata;
        vcde_pkg::CFG_BUS_GROUP:  bus_group_r  <= cfg_wdata[7:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vcde_pkg::ST_IDLE: if (in_valid && word_ok) state_nxt = vcde_pkg::ST_CALC;
      vcde_pkg::ST_CALC: state_nxt = vcde_pkg::ST_SCAN;
      vcde_pkg::ST_SCAN: if (fired_r == '0) state_nxt = vcde_pkg::ST_IDLE;
      default:           state_nxt = vcde_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    ctrl          = '0;
    unique case (state_r)
      vcde_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        ctrl.rd_en = in_valid;
      end
      vcde_pkg::ST_CALC: begin
        ctrl.wr_en = 1'b1;
        ctrl.calc  = 1'b1;
      end
      vcde_pkg::ST_SCAN: begin
        // a pending event waits for a free output slot
        ctrl.step     = (fired_r != '0) && (!fired_r[0] || out_free);
        ctrl.load_out = (fired_r != '0) && fired_r[0] && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vcde_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- state memory and counter update ----------------
  vcde_state_mem #(
    .WORDS (WORDS),
    .DW    (DW),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (ctrl.rd_en),
    .rd_addr (AW'(in_word_index)),
    .rd_data (rd_data),
    .wr_en   (ctrl.wr_en),
    .wr_addr (AW'(widx_r)),
    .wr_data (wr_data)
  );

  // memory word layout: {stable_inv, cnt_high, cnt_low}
  vcde_update #(
    .WORD_BITS (WORD_BITS)
  ) u_update (
    .sample         (sample_r),
    .cnt_low        (rd_data[WORD_BITS-1:0]),
    .cnt_high       (rd_data[2*WORD_BITS-1:WORD_BITS]),
    .stable_inv     (rd_data[DW-1:2*WORD_BITS]),
    .cnt_low_nxt    (cl_nxt),
    .cnt_high_nxt   (ch_nxt),
    .stable_inv_nxt (si_nxt),
    .fired          (fired)
  );

  assign wr_data = {si_nxt, ch_nxt, cl_nxt};

  assign contact_base = 16'(bus_group_r) * vcde_pkg::GROUP_SCALE
                      + 16'(widx_r) * 16'(WORD_BITS) + 16'd1;

  // ---------------- scan datapath ----------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= WORD_BITS'(in_sample_word);  // bits above WORD_BITS dropped
      widx_r   <= in_word_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fired_r <= '0;
    end else if (ctrl.calc) begin
      fired_r <= fired;
    end else if (ctrl.step) begin
      fired_r <= fired_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.calc) begin
      level_r   <= sample_r;
      contact_r <= contact_base;
    end else if (ctrl.step) begin
      level_r   <= level_r >> 1;
      contact_r <= contact_r + 16'd1;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_frame_id_r      <= vcde_pkg::FRAME_BASE
                           | {16'd0, event_hash_r & vcde_pkg::HASH_MASK};
      out_device_number_r <= device_id_r;
      out_contact_r       <= contact_r;
      out_old_level_r     <= ~level_r[0];
      out_new_level_r     <= level_r[0];
      out_last_event_r    <= last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_id      = out_frame_id_r;
  assign out_device_number = out_device_number_r;
  assign out_contact       = out_contact_r;
  assign out_old_level     = out_old_level_r;
  assign out_new_level     = out_new_level_r;
  assign out_last_event    = out_last_event_r;

  // ---------------- assertions ----------------
  // update cycle only follows an accepted sample
  `VCDE_ASSERT_SAME(a_calc_after_accept, clk, rst_n,
    state_r == vcde_pkg::ST_CALC, $past(in_valid && in_ready))
  // an empty scan mask ends the item
  `VCDE_ASSERT_NEXT(a_scan_done_idle, clk, rst_n,
    state_r == vcde_pkg::ST_SCAN && fired_r == '0, state_r == vcde_pkg::ST_IDLE)
  // the event marked last leaves nothing to scan
  `VCDE_ASSERT_NEXT(a_last_empties_mask, clk, rst_n,
    ctrl.load_out && last_nxt, fired_r == '0)
  // a non-final event means the scan is still running
  `VCDE_ASSERT_SAME(a_more_events_pending, clk, rst_n,
    out_valid_r && !out_last_event_r, state_r == vcde_pkg::ST_SCAN && fired_r != '0)

endmodule

### tb/sv/tb_vertical_counter_debounce_events_unit.sv
module tb_vertical_counter_debounce_events_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORDS      = 4;
  localparam int WORD_BITS  = 32;
  // index past the last register, writes to it must be dropped
  localparam vcde_pkg::cfg_idx_t CFG_UNUSED = 2'd3;
  // worst case per sample: accept + update + full 32-bit scan, plus margin
  localparam int SETTLE_CYCLES = WORD_BITS + 8;
  // cycles without any transaction before the run is declared hung
  localparam int HANG_LIMIT = 4000;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [31:0] frame_id;
    logic [15:0] device_number;
    logic [15:0] contact;
    logic        old_level;
    logic        new_level;
    logic        last_event;
  } contact_event_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  vcde_pkg::cfg_idx_t  cfg_index;
  logic [15:0]         cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [31:0]         in_sample_word;
  logic [1:0]          in_word_index;
  logic                out_valid;
  logic                out_ready;
  logic [31:0]         out_frame_id;
  logic [15:0]         out_device_number;
  logic [15:0]         out_contact;
  logic                out_old_level;
  logic                out_new_level;
  logic                out_last_event;

  // shadow of the block: counter planes, inverted debounced levels, registers
  logic [WORD_BITS-1:0] shadow_cnt_lo [WORDS];
  logic [WORD_BITS-1:0] shadow_cnt_hi [WORDS];
  logic [WORD_BITS-1:0] shadow_stable_n [WORDS];
  logic [15:0] shadow_hash;
  logic [15:0] shadow_device;
  logic [7:0]  shadow_group;

  contact_event_t pending_events [$];

  int mismatch_count = 0;
  int samples_sent   = 0;
  int hang_cycles    = 0;
  // 1-in-N chance of an idle burst on each side; 0 disables idling
  int idle_odds      = 0;
  int stall_left     = 0;

  vertical_counter_debounce_events_unit #(
    .WORDS     (WORDS),
    .WORD_BITS (WORD_BITS)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_word    (in_sample_word),
    .in_word_index     (in_word_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_id      (out_frame_id),
    .out_device_number (out_device_number),
    .out_contact       (out_contact),
    .out_old_level     (out_old_level),
    .out_new_level     (out_new_level),
    .out_last_event    (out_last_event)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: run one accepted sample through the shadow counters and queue
  // one event per debounced change, lowest bit first, last one flagged.
  // ---------------------------------------------------------------------------
  function automatic void debounce_sample(logic [31:0] sample, logic [1:0] word);
    logic [WORD_BITS-1:0] diff;
    logic [WORD_BITS-1:0] fired;
    logic [15:0]          contact_base;
    contact_event_t       ev;
    int                   last_pos;
    diff  = shadow_stable_n[word] ^ ~sample[WORD_BITS-1:0];
    shadow_cnt_lo[word] = ~(shadow_cnt_lo[word] & diff);
    shadow_cnt_hi[word] = shadow_cnt_lo[word] ^ (shadow_cnt_hi[word] & diff);
    fired = diff & shadow_cnt_lo[word] & shadow_cnt_hi[word];
    shadow_stable_n[word] ^= fired;
    contact_base = 16'(shadow_group) * vcde_pkg::GROUP_SCALE
                 + 16'(word) * 16'(WORD_BITS) + 16'd1;
    last_pos = -1;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (fired[b]) begin
        ev.frame_id      = vcde_pkg::FRAME_BASE
                         | {16'h0000, shadow_hash & vcde_pkg::HASH_MASK};
        ev.device_number = shadow_device;
        ev.contact       = contact_base + 16'(b);
        ev.new_level     = sample[b];
        ev.old_level     = ~sample[b];
        ev.last_event    = 1'b0;
        pending_events.push_back(ev);
        last_pos = pending_events.size() - 1;
      end
    end
    if (last_pos >= 0) pending_events[last_pos].last_event = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every event transaction against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    contact_event_t got;
    contact_event_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_frame_id, out_device_number, out_contact,
              out_old_level, out_new_level, out_last_event};
      if (pending_events.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("[%0t] unexpected event: frame %h dev %h contact %0d old %b new %b last %b",
                   $realtime, got.frame_id, got.device_number, got.contact,
                   got.old_level, got.new_level, got.last_event);
      end else begin
        want = pending_events.pop_front();
        if (got.frame_id !== want.frame_id || got.device_number !== want.device_number ||
            got.contact !== want.contact || got.old_level !== want.old_level ||
            got.new_level !== want.new_level || got.last_event !== want.last_event) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("[%0t] event mismatch", $realtime);
            $display("  expected: frame %h dev %h contact %0d old %b new %b last %b",
                     want.frame_id, want.device_number, want.contact,
                     want.old_level, want.new_level, want.last_event);
            $display("  actual  : frame %h dev %h contact %0d old %b new %b last %b",
                     got.frame_id, got.device_number, got.contact,
                     got.old_level, got.new_level, got.last_event);
          end
        end
      end
    end
  end

  // Receiver: random back-pressure bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      stall_left <= $urandom_range(1, 5) - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: any transaction on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // One sample transaction. Valid is left high after acceptance so that a
  // back-to-back item does not see two assignments in one step; anything
  // that lets time pass afterwards drops it first (see wait_block_idle).
  task automatic send_sample(input logic [31:0] sample, input logic [1:0] word);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample_word <= sample;
    in_word_index  <= word;
    do @(posedge clk); while (!in_ready);
    debounce_sample(sample, word);
    samples_sent++;
  endtask

  // All events out, then room for a sample that produced none to finish.
  task automatic wait_block_idle();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes every register, then a junk write to the unused index.
  task automatic program_regs(input logic [15:0] hash, input logic [15:0] dev,
                              input logic [15:0] grp, input logic [15:0] junk);
    wait_block_idle();
    cfg_we    <= 1'b1;
    cfg_index <= vcde_pkg::CFG_EVENT_HASH;
    cfg_wdata <= hash;
    @(posedge clk);
    shadow_hash = hash;
    cfg_index <= vcde_pkg::CFG_DEVICE_ID;
    cfg_wdata <= dev;
    @(posedge clk);
    shadow_device = dev;
    cfg_index <= vcde_pkg::CFG_BUS_GROUP;
    cfg_wdata <= grp;
    @(posedge clk);
    shadow_group = grp[7:0];
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= junk;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset config: word 0 all rising then all falling, 32 events each way.
  task automatic test_full_word_toggle();
    repeat (4) send_sample(32'hffff_ffff, 2'd0);
    repeat (4) send_sample(32'h0000_0000, 2'd0);
  endtask

  // Registers at their maximum; upper bits of the group write are dropped.
  task automatic test_config_extremes();
    program_regs(16'hffff, 16'hffff, 16'hffff, 16'h5a5a);
    repeat (4) send_sample(32'h8000_0001, 2'd3);
  endtask

  // A sample agreeing with the debounced level restarts the count.
  task automatic test_interrupted_count();
    program_regs(16'h1234, 16'hbeef, 16'h0042, 16'hffff);
    repeat (3) send_sample(32'h0000_00f0, 2'd1);
    send_sample(32'h0000_0000, 2'd1);
    repeat (3) send_sample(32'h0000_00f0, 2'd1);
    send_sample(32'h0000_00f0, 2'd1);
    // already debounced: no repeat event
    send_sample(32'h0000_00f0, 2'd1);
  endtask

  // Samples that match the debounced level yield no events.
  task automatic test_no_change();
    program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    repeat (2) send_sample(32'h0000_0000, 2'd2);
  endtask

  // Mostly steady runs of 4..6 identical samples around the current level,
  // with short broken runs and pure noise mixed in.
  task automatic test_random_runs(input int n_items, input bit quiet);
    int          stop_at;
    logic [1:0]  word;
    logic [31:0] flip;
    logic [31:0] target;
    stop_at = samples_sent + n_items;
    while (samples_sent < stop_at) begin
      if (quiet) idle_odds = 0;
      else idle_odds = ($urandom_range(0, 3) == 0) ? 0 : 3;
      word = 2'($urandom_range(0, WORDS - 1));
      case ($urandom_range(0, 3))
        0:       flip = $urandom & $urandom & $urandom;
        1:       flip = $urandom;
        2:       flip = 32'hffff_ffff;
        default: flip = 32'h1 << $urandom_range(0, 31);
      endcase
      target = ~shadow_stable_n[word] ^ flip;
      case ($urandom_range(0, 9))
        0, 1: send_sample($urandom, word);
        2: begin
          repeat ($urandom_range(1, 3)) send_sample(target, word);
          send_sample(target ^ $urandom, word);
        end
        default: repeat ($urandom_range(4, 6)) send_sample(target, word);
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = vcde_pkg::CFG_EVENT_HASH;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_sample_word = '0;
    in_word_index  = '0;
    for (int w = 0; w < WORDS; w++) begin
      shadow_cnt_lo[w]   = '1;
      shadow_cnt_hi[w]   = '1;
      shadow_stable_n[w] = '1;
    end
    shadow_hash   = '0;
    shadow_device = '0;
    shadow_group  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_odds = 3;
    test_full_word_toggle();
    test_config_extremes();
    test_interrupted_count();
    test_no_change();

    program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    test_random_runs(100, 1'b0);
    program_regs(16'hffff, 16'h0000, 16'h00ff, 16'($urandom));
    test_random_runs(100, 1'b0);
    program_regs(16'h0000, 16'hffff, 16'h0000, 16'($urandom));
    test_random_runs(100, 1'b0);
    // tail: random config, both sides always ready
    program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    test_random_runs(100, 1'b1);

    wait_block_idle();
    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/vcde_pkg.sv
hw/rtl/vcde_state_mem.sv
hw/rtl/vcde_update.sv
hw/rtl/vertical_counter_debounce_events_unit.sv
tb/sv/tb_vertical_counter_debounce_events_unit.sv
